[sv/rlcam_pkg.sv]
`default_nettype none
package rlcam_pkg;

  localparam int unsigned SnWidth = 10;
  localparam int unsigned SegOffsetWidth = 15;
  localparam logic [SnWidth-1:0] SnStart = 10'd1;
  localparam logic [SnWidth-1:0] AckTimeoutReset = 10'd60;

  typedef enum logic [1:0] {
    OP_BUILD = 2'd0,
    OP_RECV  = 2'd1,
    OP_TICK  = 2'd2,
    OP_RESEQ = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REPLY_NONE   = 2'd0,
    REPLY_HEADER = 2'd1,
    REPLY_STATUS = 2'd2
  } reply_kind_t;

  typedef enum logic [1:0] {
    PDU_NONE   = 2'd0,
    PDU_DATA   = 2'd1,
    PDU_STATUS = 2'd2,
    PDU_OTHER  = 2'd3
  } pdu_kind_t;

  // D/C = 1 and P = 1 in the first header byte
  localparam logic [5:0] HeaderFlags = 6'b101000;

  typedef struct packed {
    reply_kind_t                reply_kind;
    logic [7:0]                 reply_byte0;
    logic [7:0]                 reply_byte1;
    logic                       timeout;
    logic                       restart_ignored;
    pdu_kind_t                  pdu_kind;
    logic                       pdu_rf;
    logic [1:0]                 pdu_fi;
    logic                       pdu_ext;
    logic [SnWidth-1:0]         pdu_sn;
    logic                       pdu_last_seg;
    logic [SegOffsetWidth-1:0]  pdu_seg_offset;
  } result_t;

endpackage
`default_nettype wire

[sv/rlc_am_header_and_poll_control_core.sv]
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while out_ready is high; the input
// register takes a request while a finished result waits for out_ready
// only if the input register is empty.
// Reset (rst, synchronous): next SN 1, acked SN 0, timer stopped at 0,
// timer reload 60, both stages empty.
`default_nettype none
module rlc_am_header_and_poll_control_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [1:0]                            opcode,
  input  wire logic [7:0]                            byte0,
  input  wire logic [7:0]                            byte1,
  input  wire logic [7:0]                            byte2,
  input  wire logic [7:0]                            byte3,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [1:0]                                 reply_kind,
  output logic [7:0]                                 reply_byte0,
  output logic [7:0]                                 reply_byte1,
  output logic                                       timeout,
  output logic                                       restart_ignored,
  output logic [1:0]                                 pdu_kind,
  output logic                                       pdu_rf,
  output logic [1:0]                                 pdu_fi,
  output logic                                       pdu_ext,
  output logic [rlcam_pkg::SnWidth-1:0]              pdu_sn,
  output logic                                       pdu_last_seg,
  output logic [rlcam_pkg::SegOffsetWidth-1:0]       pdu_seg_offset,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [rlcam_pkg::SnWidth-1:0]         cfg_data
);
  import rlcam_pkg::*;

  logic [SnWidth-1:0] ack_timeout_ticks;
  logic [SnWidth-1:0] next_sn, next_sn_next;
  logic [SnWidth-1:0] acked_sn, acked_sn_next;
  logic               timer_running, timer_running_next;
  logic [SnWidth-1:0] timer_count, timer_count_next;

  logic       req_valid;
  opcode_t    req_op;
  logic [7:0] req_b0, req_b1, req_b2, req_b3;
  logic       req_advance;

  result_t            res, res_next;
  logic [SnWidth-1:0] rx_sn, ack_sn;

  assign cfg_ready   = 1'b1;
  assign req_advance = req_valid && (!out_valid || out_ready);
  assign in_ready    = !req_valid || req_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_ticks <= AckTimeoutReset;
    end else if (cfg_valid && cfg_ready) begin
      ack_timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op <= opcode_t'(opcode);
      req_b0 <= byte0;
      req_b1 <= byte1;
      req_b2 <= byte2;
      req_b3 <= byte3;
    end
  end

  assign rx_sn  = {req_b0[1:0], req_b1};
  assign ack_sn = rx_sn + SnWidth'(1);

  always_comb begin
    res_next           = '0;
    res_next.reply_kind = REPLY_NONE;
    res_next.pdu_kind   = PDU_NONE;
    next_sn_next       = next_sn;
    acked_sn_next      = acked_sn;
    timer_running_next = timer_running;
    timer_count_next   = timer_count;
    case (req_op)
      OP_BUILD: begin
        res_next.reply_kind  = REPLY_HEADER;
        res_next.reply_byte0 = {HeaderFlags, next_sn[9:8]};
        res_next.reply_byte1 = next_sn[7:0];
        next_sn_next         = next_sn + SnWidth'(1);
        if (!timer_running || timer_count == '0) begin
          timer_running_next = 1'b1;
          timer_count_next   = ack_timeout_ticks;
        end else begin
          res_next.restart_ignored = 1'b1;
        end
      end
      OP_RECV: begin
        if (req_b0[7]) begin
          res_next.pdu_kind = PDU_DATA;
          res_next.pdu_rf   = req_b0[6];
          res_next.pdu_fi   = req_b0[4:3];
          res_next.pdu_ext  = req_b0[2];
          res_next.pdu_sn   = rx_sn;
          if (req_b0[6]) begin
            res_next.pdu_last_seg   = req_b2[7];
            res_next.pdu_seg_offset = {req_b2[6:0], req_b3};
          end
          if (req_b0[5]) begin
            res_next.reply_kind  = REPLY_STATUS;
            res_next.reply_byte0 = {4'b0000, ack_sn[9:6]};
            res_next.reply_byte1 = {ack_sn[5:0], 2'b00};
          end
        end else if (req_b0[6:4] == 3'b000) begin
          acked_sn_next      = {req_b0[3:0], req_b1[7:2]};
          timer_running_next = 1'b0;
          timer_count_next   = '0;
          res_next.pdu_kind  = PDU_STATUS;
          res_next.pdu_sn    = {req_b0[3:0], req_b1[7:2]};
        end else begin
          res_next.pdu_kind = PDU_OTHER;
        end
      end
      OP_TICK: begin
        if (timer_running) begin
          if (timer_count == '0) begin
            res_next.timeout = 1'b1;
          end else begin
            timer_count_next = timer_count - SnWidth'(1);
          end
        end
      end
      OP_RESEQ: begin
        next_sn_next = SnStart;
      end
      default: begin
        next_sn_next = next_sn;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_sn       <= SnStart;
      acked_sn      <= '0;
      timer_running <= 1'b0;
      timer_count   <= '0;
    end else if (req_advance) begin
      next_sn       <= next_sn_next;
      acked_sn      <= acked_sn_next;
      timer_running <= timer_running_next;
      timer_count   <= timer_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_advance) begin
      res <= res_next;
    end
  end

  assign reply_kind      = res.reply_kind;
  assign reply_byte0     = res.reply_byte0;
  assign reply_byte1     = res.reply_byte1;
  assign timeout         = res.timeout;
  assign restart_ignored = res.restart_ignored;
  assign pdu_kind        = res.pdu_kind;
  assign pdu_rf          = res.pdu_rf;
  assign pdu_fi          = res.pdu_fi;
  assign pdu_ext         = res.pdu_ext;
  assign pdu_sn          = res.pdu_sn;
  assign pdu_last_seg    = res.pdu_last_seg;
  assign pdu_seg_offset  = res.pdu_seg_offset;

`ifndef SYNTHESIS
  a_stopped_count_zero: assert property (@(posedge clk) disable iff (rst)
    !timer_running |-> timer_count == '0)
    else $error("timer stopped with nonzero count");

  a_timeout_only_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout |-> reply_kind == REPLY_NONE && pdu_kind == PDU_NONE)
    else $error("timeout on a non-tick result");

  a_restart_on_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && restart_ignored |-> reply_kind == REPLY_HEADER)
    else $error("restart_ignored without a built header");

  a_build_starts_timer: assert property (@(posedge clk) disable iff (rst)
    req_advance && req_op == OP_BUILD |=> timer_running)
    else $error("timer not running after header build");

  a_status_stops_timer: assert property (@(posedge clk) disable iff (rst)
    req_advance && req_op == OP_RECV && !req_b0[7] && req_b0[6:4] == 3'b000
    |=> !timer_running && acked_sn == pdu_sn)
    else $error("status PDU did not stop timer");
`endif

endmodule
`default_nettype wire

[bench/tb_rlc_am_header_and_poll_control_core.sv]
`timescale 1ns / 1ps
module tb_rlc_am_header_and_poll_control_core;
  import rlcam_pkg::*;

  localparam logic [7:0] DataHdrBase = 8'hA0;
  localparam logic [9:0] SnAfterReseq = 10'd1;
  localparam result_t Quiet = '0;
  localparam int unsigned RandomPerPhase = 80;
  localparam int unsigned BuildRun = 350;
  localparam int unsigned ChokeCycles = 300;
  localparam int unsigned IdleLimit = 5000;

  typedef struct {
    opcode_t op;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    bit has_lit;
    result_t lit;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = 2'd0;
  logic [7:0] byte0 = 8'd0;
  logic [7:0] byte1 = 8'd0;
  logic [7:0] byte2 = 8'd0;
  logic [7:0] byte3 = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] reply_kind;
  logic [7:0] reply_byte0;
  logic [7:0] reply_byte1;
  logic timeout;
  logic restart_ignored;
  logic [1:0] pdu_kind;
  logic pdu_rf;
  logic [1:0] pdu_fi;
  logic pdu_ext;
  logic [SnWidth-1:0] pdu_sn;
  logic pdu_last_seg;
  logic [SegOffsetWidth-1:0] pdu_seg_offset;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SnWidth-1:0] cfg_data = '0;

  rlc_am_header_and_poll_control_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
    .out_valid(out_valid), .out_ready(out_ready),
    .reply_kind(reply_kind), .reply_byte0(reply_byte0), .reply_byte1(reply_byte1),
    .timeout(timeout), .restart_ignored(restart_ignored),
    .pdu_kind(pdu_kind), .pdu_rf(pdu_rf), .pdu_fi(pdu_fi), .pdu_ext(pdu_ext),
    .pdu_sn(pdu_sn), .pdu_last_seg(pdu_last_seg), .pdu_seg_offset(pdu_seg_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [9:0] sn_next = SnStart;
  logic [9:0] sn_acked = '0;
  logic timer_on = 1'b0;
  logic [9:0] timer_left = '0;
  logic [9:0] reload_ticks = AckTimeoutReset;

  request_t request_q[$];
  request_t directed_tab[$];
  result_t pending_results[$];
  request_t cur;
  request_t build_req;
  result_t want;
  result_t predicted;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned choke_left = 0;
  int unsigned choke_cnt = 0;
  int unsigned choke_seen = 0;
  int unsigned idle_cycles = 0;
  bit steady = 1'b0;
  int errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_timeouts = 0;
  int unsigned n_status = 0;
  int unsigned n_ignored = 0;

  function automatic int unsigned pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic compute_reply(input request_t r, output result_t e);
    logic [9:0] sn;
    logic [9:0] ack;
    e = '0;
    case (r.op)
      OP_BUILD: begin
        e.reply_kind = REPLY_HEADER;
        e.reply_byte0 = DataHdrBase | {6'd0, sn_next[9:8]};
        e.reply_byte1 = sn_next[7:0];
        sn_next = sn_next + 10'd1;
        if (!timer_on || timer_left == 10'd0) begin
          timer_on = 1'b1;
          timer_left = reload_ticks;
        end else begin
          e.restart_ignored = 1'b1;
        end
      end
      OP_RECV: begin
        if (r.b0[7]) begin
          sn = {r.b0[1:0], r.b1};
          e.pdu_kind = PDU_DATA;
          e.pdu_rf = r.b0[6];
          e.pdu_fi = r.b0[4:3];
          e.pdu_ext = r.b0[2];
          e.pdu_sn = sn;
          if (r.b0[6]) begin
            e.pdu_last_seg = r.b2[7];
            e.pdu_seg_offset = {r.b2[6:0], r.b3};
          end
          if (r.b0[5]) begin
            ack = sn + 10'd1;
            e.reply_kind = REPLY_STATUS;
            e.reply_byte0 = {4'd0, ack[9:6]};
            e.reply_byte1 = {ack[5:0], 2'b00};
          end
        end else if (r.b0[6:4] == 3'b000) begin
          sn_acked = {r.b0[3:0], r.b1[7:2]};
          timer_on = 1'b0;
          timer_left = '0;
          e.pdu_kind = PDU_STATUS;
          e.pdu_sn = sn_acked;
        end else begin
          e.pdu_kind = PDU_OTHER;
        end
      end
      OP_TICK: begin
        if (timer_on) begin
          if (timer_left == 10'd0) e.timeout = 1'b1;
          else timer_left = timer_left - 10'd1;
        end
      end
      default: sn_next = SnAfterReseq;
    endcase
  endtask

  function automatic request_t rand_request();
    request_t r;
    int unsigned pick;
    int unsigned kind;
    r.b0 = 8'($urandom);
    r.b1 = 8'($urandom);
    r.b2 = 8'($urandom);
    r.b3 = 8'($urandom);
    r.has_lit = 1'b0;
    r.lit = Quiet;
    pick = $urandom_range(99);
    kind = $urandom_range(99);
    if (pick < 30) begin
      r.op = OP_BUILD;
    end else if (pick < 70) begin
      r.op = OP_RECV;
      if (kind < 60) begin
        r.b0[7] = 1'b1;
      end else if (kind < 85) begin
        r.b0[7:4] = 4'b0000;
      end else begin
        r.b0[7] = 1'b0;
        if (r.b0[6:4] == 3'b000) r.b0[6:4] = 3'($urandom_range(1, 7));
      end
    end else if (pick < 98) begin
      r.op = OP_TICK;
    end else begin
      r.op = OP_RESEQ;
    end
    return r;
  endfunction

  task automatic add_row(input opcode_t op, input logic [7:0] b0, input logic [7:0] b1,
                         input logic [7:0] b2, input logic [7:0] b3, input bit has,
                         input result_t lit);
    request_t r;
    r.op = op;
    r.b0 = b0;
    r.b1 = b1;
    r.b2 = b2;
    r.b3 = b3;
    r.has_lit = has;
    r.lit = lit;
    directed_tab.insert(directed_tab.size(), r);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reload(input logic [9:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    reload_ticks = v;
    cfg_valid <= 1'b0;
  endtask

  // request side: hold payload until accepted, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        compute_reply(cur, predicted);
        pending_results.insert(pending_results.size(), cur.has_lit ? cur.lit : predicted);
        n_sent++;
        if (predicted.timeout) n_timeouts++;
        if (predicted.reply_kind == REPLY_STATUS) n_status++;
        if (predicted.restart_ignored) n_ignored++;
      end
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (request_q.size() != 0) begin
        cur = request_q.pop_front();
        in_valid <= 1'b1;
        opcode <= cur.op;
        byte0 <= cur.b0;
        byte1 <= cur.b1;
        byte2 <= cur.b2;
        byte3 <= cur.b3;
        if (!steady && $urandom_range(3) == 0) tx_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (choke_left != 0) begin
      out_ready <= 1'b0;
      choke_left <= choke_left - 1;
    end else if (choke_seen != choke_cnt) begin
      out_ready <= 1'b0;
      choke_seen <= choke_cnt;
      choke_left <= ChokeCycles;
    end else if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(3) == 0) rx_gap <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("reply_kind", 32'(want.reply_kind), 32'(reply_kind));
        check_field("reply_byte0", 32'(want.reply_byte0), 32'(reply_byte0));
        check_field("reply_byte1", 32'(want.reply_byte1), 32'(reply_byte1));
        check_field("timeout", 32'(want.timeout), 32'(timeout));
        check_field("restart_ignored", 32'(want.restart_ignored), 32'(restart_ignored));
        check_field("pdu_kind", 32'(want.pdu_kind), 32'(pdu_kind));
        check_field("pdu_rf", 32'(want.pdu_rf), 32'(pdu_rf));
        check_field("pdu_fi", 32'(want.pdu_fi), 32'(pdu_fi));
        check_field("pdu_ext", 32'(want.pdu_ext), 32'(pdu_ext));
        check_field("pdu_sn", 32'(want.pdu_sn), 32'(pdu_sn));
        check_field("pdu_last_seg", 32'(want.pdu_last_seg), 32'(pdu_last_seg));
        check_field("pdu_seg_offset", 32'(want.pdu_seg_offset), 32'(pdu_seg_offset));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  logic [9:0] reload_set[6];

  initial begin
    add_row(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, Quiet);
    add_row(OP_BUILD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
            {REPLY_HEADER, 8'hA0, 8'h01, 1'b0, 1'b0, PDU_NONE, 1'b0, 2'd0, 1'b0,
             10'd0, 1'b0, 15'd0});
    add_row(OP_BUILD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
            {REPLY_HEADER, 8'hA0, 8'h02, 1'b0, 1'b1, PDU_NONE, 1'b0, 2'd0, 1'b0,
             10'd0, 1'b0, 15'd0});
    add_row(OP_RECV, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
            {REPLY_STATUS, 8'h00, 8'h00, 1'b0, 1'b0, PDU_DATA, 1'b1, 2'd3, 1'b1,
             10'h3FF, 1'b1, 15'h7FFF});
    add_row(OP_RECV, 8'h80, 8'h00, 8'hFF, 8'hFF, 1'b1,
            {REPLY_NONE, 8'h00, 8'h00, 1'b0, 1'b0, PDU_DATA, 1'b0, 2'd0, 1'b0,
             10'd0, 1'b0, 15'd0});
    add_row(OP_RECV, 8'hA3, 8'hFE, 8'h00, 8'h00, 1'b0, Quiet);
    add_row(OP_RECV, 8'hC0, 8'h15, 8'h80, 8'h00, 1'b0, Quiet);
    add_row(OP_RECV, 8'h30, 8'hAA, 8'h55, 8'hAA, 1'b1,
            {REPLY_NONE, 8'h00, 8'h00, 1'b0, 1'b0, PDU_OTHER, 1'b0, 2'd0, 1'b0,
             10'd0, 1'b0, 15'd0});
    add_row(OP_RECV, 8'h70, 8'hFF, 8'hFF, 8'hFF, 1'b1,
            {REPLY_NONE, 8'h00, 8'h00, 1'b0, 1'b0, PDU_OTHER, 1'b0, 2'd0, 1'b0,
             10'd0, 1'b0, 15'd0});
    add_row(OP_RECV, 8'h0F, 8'hFC, 8'h00, 8'h00, 1'b1,
            {REPLY_NONE, 8'h00, 8'h00, 1'b0, 1'b0, PDU_STATUS, 1'b0, 2'd0, 1'b0,
             10'h3FF, 1'b0, 15'd0});
    add_row(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, Quiet);
    add_row(OP_BUILD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, Quiet);
    add_row(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, Quiet);
    add_row(OP_RESEQ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, Quiet);
    add_row(OP_BUILD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, Quiet);
    add_row(OP_RECV, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
            {REPLY_NONE, 8'h00, 8'h00, 1'b0, 1'b0, PDU_STATUS, 1'b0, 2'd0, 1'b0,
             10'd0, 1'b0, 15'd0});
    add_row(OP_RECV, 8'h00, 8'h03, 8'h00, 8'h00, 1'b0, Quiet);
    add_row(OP_RECV, 8'hA0, 8'hFF, 8'h00, 8'h00, 1'b0, Quiet);
    add_row(OP_RECV, 8'h9C, 8'h00, 8'h7F, 8'hFF, 1'b0, Quiet);

    reload_set[0] = 10'd0;
    reload_set[1] = 10'd1;
    reload_set[2] = 10'd1023;
    reload_set[3] = 10'd2;
    reload_set[4] = 10'($urandom_range(1, 1023));
    reload_set[5] = 10'd5;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_tab[i]) request_q.insert(request_q.size(), directed_tab[i]);

    for (int ph = 0; ph < 6; ph++) begin
      write_reload(reload_set[ph]);
      steady <= (ph == 3);
      if (ph == 1) choke_cnt <= choke_cnt + 1;
      for (int n = 0; n < RandomPerPhase; n++)
        request_q.insert(request_q.size(), rand_request());
      if (ph == 3) begin
        // long run of mostly builds, back to back
        for (int n = 0; n < BuildRun; n++) begin
          build_req = rand_request();
          if ($urandom_range(9) != 0) build_req.op = OP_BUILD;
          else if (build_req.op == OP_RESEQ) build_req.op = OP_TICK;
          request_q.insert(request_q.size(), build_req);
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("sent %0d requests over 6 reload settings, %0d results checked",
             n_sent, n_checked);
    $display("timeouts %0d, status replies %0d, ignored restarts %0d",
             n_timeouts, n_status, n_ignored);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/rlcam_pkg.sv
sv/rlc_am_header_and_poll_control_core.sv
bench/tb_rlc_am_header_and_poll_control_core.sv
